FILE: sv/segint_pkg.sv
// segint_pkg: widths, word types and queue types for the segment intersection unit
// used by every module of the block, depends on nothing
`default_nettype none
package segint_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int DW = COORD_WIDTH + 1;        // coordinate differences
  localparam int PW = 2 * DW;                 // cross products
  localparam int NW = PW + 1;                 // denominator and numerators
  localparam int MW = PW;                     // magnitude of numerator or denominator
  localparam int RW = MW + DW - 1;            // dividend of the point division
  localparam int QB = DW;                     // quotient bits on a hit
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] a_start_x;
    logic signed [COORD_WIDTH-1:0] a_start_y;
    logic signed [COORD_WIDTH-1:0] a_end_x;
    logic signed [COORD_WIDTH-1:0] a_end_y;
    logic signed [COORD_WIDTH-1:0] b_start_x;
    logic signed [COORD_WIDTH-1:0] b_start_y;
    logic signed [COORD_WIDTH-1:0] b_end_x;
    logic signed [COORD_WIDTH-1:0] b_end_y;
  } seg_in_t;

  typedef struct packed {
    logic                          hit;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
  } seg_out_t;

  // classified item handed from front to back
  typedef struct packed {
    logic                          hit;
    logic signed [COORD_WIDTH-1:0] sax;
    logic signed [COORD_WIDTH-1:0] say;
    logic signed [DW-1:0]          dax;
    logic signed [DW-1:0]          day;
    logic signed [NW-1:0]          na;
    logic signed [NW-1:0]          den;
  } qword_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage
`default_nettype wire

FILE: sv/segint_front.sv
// segint_front: differences, cross products and hit test, three registered stages
// depends on segint_pkg
`default_nettype none
module segint_front
  import segint_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire seg_in_t seg,
  input  wire logic    seg_valid,
  output logic         seg_ready,
  output logic         push_valid,
  output qword_t       push_word,
  input  wire qstat_t  qstat
);

  logic f_en;
  logic f1_valid, f2_valid, f3_valid;
  logic signed [COORD_WIDTH-1:0] f1_sax, f1_say, f2_sax, f2_say, f3_sax, f3_say;
  logic signed [DW-1:0] f1_dax, f1_day, f1_dbx, f1_dby, f1_ox, f1_oy;
  logic signed [DW-1:0] f2_dax, f2_day, f3_dax, f3_day;
  logic signed [PW-1:0] f2_p0, f2_p1, f2_p2, f2_p3, f2_p4, f2_p5;
  logic signed [NW-1:0] f3_den, f3_na, f3_nb;
  logic ua_ok, ub_ok, hit;

  assign f_en       = !f3_valid || !qstat.full;
  assign seg_ready  = f_en;
  assign push_valid = f3_valid && !qstat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      f3_valid <= 1'b0;
    end else if (f_en) begin
      f1_valid <= seg_valid;
      f2_valid <= f1_valid;
      f3_valid <= f2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f_en) begin
      f1_sax <= seg.a_start_x;
      f1_say <= seg.a_start_y;
      f1_dax <= DW'(seg.a_end_x) - DW'(seg.a_start_x);
      f1_day <= DW'(seg.a_end_y) - DW'(seg.a_start_y);
      f1_dbx <= DW'(seg.b_end_x) - DW'(seg.b_start_x);
      f1_dby <= DW'(seg.b_end_y) - DW'(seg.b_start_y);
      f1_ox  <= DW'(seg.a_start_x) - DW'(seg.b_start_x);
      f1_oy  <= DW'(seg.a_start_y) - DW'(seg.b_start_y);

      f2_sax <= f1_sax;
      f2_say <= f1_say;
      f2_dax <= f1_dax;
      f2_day <= f1_day;
      f2_p0  <= PW'(f1_dby) * PW'(f1_dax);
      f2_p1  <= PW'(f1_dbx) * PW'(f1_day);
      f2_p2  <= PW'(f1_dbx) * PW'(f1_oy);
      f2_p3  <= PW'(f1_dby) * PW'(f1_ox);
      f2_p4  <= PW'(f1_dax) * PW'(f1_oy);
      f2_p5  <= PW'(f1_day) * PW'(f1_ox);

      f3_sax <= f2_sax;
      f3_say <= f2_say;
      f3_dax <= f2_dax;
      f3_day <= f2_day;
      f3_den <= NW'(f2_p0) - NW'(f2_p1);
      f3_na  <= NW'(f2_p2) - NW'(f2_p3);
      f3_nb  <= NW'(f2_p4) - NW'(f2_p5);
    end
  end

  // parameter in [0,1] without division, sign of den decides the direction
  always_comb begin
    if (f3_den < 0) begin
      ua_ok = (f3_na <= 0) && (f3_na >= f3_den);
      ub_ok = (f3_nb <= 0) && (f3_nb >= f3_den);
    end else begin
      ua_ok = (f3_na >= 0) && (f3_na <= f3_den);
      ub_ok = (f3_nb >= 0) && (f3_nb <= f3_den);
    end
    hit = (f3_den != 0) && ua_ok && ub_ok;
  end

  always_comb begin
    push_word.hit = hit;
    push_word.sax = f3_sax;
    push_word.say = f3_say;
    push_word.dax = f3_dax;
    push_word.day = f3_day;
    push_word.na  = f3_na;
    push_word.den = f3_den;
  end

endmodule
`default_nettype wire

FILE: sv/segint_queue.sv
// segint_queue: short word queue between front and back
// depends on segint_pkg
`default_nettype none
module segint_queue
  import segint_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire qword_t push_word,
  input  wire logic   pop,
  output qword_t      pop_word,
  output qstat_t      qstat
);

  qword_t         mem [0:QDEPTH-1];
  logic [QAW-1:0] wptr, rptr;
  logic [QAW:0]   cnt;

  assign qstat.full  = (cnt == (QAW+1)'(QDEPTH));
  assign qstat.empty = (cnt == '0);
  assign pop_word    = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/segint_back.sv
// segint_back: point computation, split multiply then pipelined restoring divider
// depends on segint_pkg
`default_nettype none
module segint_back
  import segint_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire qword_t   pop_word,
  input  wire qstat_t   qstat,
  output logic          pop,
  output seg_out_t      res,
  output logic          res_valid,
  input  wire logic     res_ready
);

  localparam int HW = DW;  // width of one numerator half

  logic b_en;
  logic   m1_valid;
  qword_t m1_w;

  logic [MW-1:0] na_abs, den_abs;
  logic [DW-1:0] dax_abs, day_abs;

  logic m2_valid, m2_hit, m2_sx, m2_sy;
  logic signed [COORD_WIDTH-1:0] m2_sax, m2_say;
  logic [MW-1:0] m2_den;
  logic [2*HW-1:0] m2_lx, m2_hx, m2_ly, m2_hy;

  logic                          dv_valid [0:QB];
  logic                          dv_hit   [0:QB];
  logic                          dv_sx    [0:QB];
  logic                          dv_sy    [0:QB];
  logic signed [COORD_WIDTH-1:0] dv_sax   [0:QB];
  logic signed [COORD_WIDTH-1:0] dv_say   [0:QB];
  logic [MW-1:0]                 dv_den   [0:QB];
  logic [RW-1:0]                 dv_rx    [0:QB];
  logic [RW-1:0]                 dv_ry    [0:QB];
  logic [QB-1:0]                 dv_qx    [0:QB];
  logic [QB-1:0]                 dv_qy    [0:QB];

  logic signed [COORD_WIDTH-1:0] px, py;

  assign b_en = !res_valid || res_ready;
  assign pop  = b_en && !qstat.empty;

  function automatic logic signed [COORD_WIDTH-1:0] place(
    input logic signed [COORD_WIDTH-1:0] s, input logic neg, input logic [QB-1:0] q);
    logic signed [QB:0]            qs;
    logic signed [COORD_WIDTH+2:0] sum;
    logic signed [COORD_WIDTH+2:0] hi, lo;
    qs  = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    sum = (COORD_WIDTH+3)'(s) + (COORD_WIDTH+3)'(qs);
    hi  = (COORD_WIDTH+3)'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    lo  = -hi - 1;
    if (sum > hi)      place = hi[COORD_WIDTH-1:0];
    else if (sum < lo) place = lo[COORD_WIDTH-1:0];
    else               place = sum[COORD_WIDTH-1:0];
  endfunction

  always_comb begin
    na_abs  = m1_w.na[NW-1]  ? MW'(-m1_w.na)  : MW'(m1_w.na);
    den_abs = m1_w.den[NW-1] ? MW'(-m1_w.den) : MW'(m1_w.den);
    dax_abs = m1_w.dax[DW-1] ? DW'(-m1_w.dax) : DW'(m1_w.dax);
    day_abs = m1_w.day[DW-1] ? DW'(-m1_w.day) : DW'(m1_w.day);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid    <= 1'b0;
      m2_valid    <= 1'b0;
      dv_valid[0] <= 1'b0;
    end else if (b_en) begin
      m1_valid    <= !qstat.empty;
      m2_valid    <= m1_valid;
      dv_valid[0] <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      m1_w   <= pop_word;
      m2_hit <= m1_w.hit;
      m2_sx  <= m1_w.dax[DW-1];
      m2_sy  <= m1_w.day[DW-1];
      m2_sax <= m1_w.sax;
      m2_say <= m1_w.say;
      m2_den <= den_abs;
      m2_lx  <= (2*HW)'(na_abs[HW-1:0])  * (2*HW)'(dax_abs);
      m2_hx  <= (2*HW)'(na_abs[MW-1:HW]) * (2*HW)'(dax_abs);
      m2_ly  <= (2*HW)'(na_abs[HW-1:0])  * (2*HW)'(day_abs);
      m2_hy  <= (2*HW)'(na_abs[MW-1:HW]) * (2*HW)'(day_abs);

      dv_hit[0] <= m2_hit;
      dv_sx[0]  <= m2_sx;
      dv_sy[0]  <= m2_sy;
      dv_sax[0] <= m2_sax;
      dv_say[0] <= m2_say;
      dv_den[0] <= m2_den;
      dv_rx[0]  <= (RW'(m2_hx) << HW) + RW'(m2_lx);
      dv_ry[0]  <= (RW'(m2_hy) << HW) + RW'(m2_ly);
      dv_qx[0]  <= '0;
      dv_qy[0]  <= '0;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int B = QB - 1 - k;
    logic [RW-1:0] dsh;
    logic          gx, gy;
    assign dsh = RW'(dv_den[k]) << B;
    assign gx  = dv_rx[k] >= dsh;
    assign gy  = dv_ry[k] >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k+1] <= 1'b0;
      end else if (b_en) begin
        dv_valid[k+1] <= dv_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (b_en) begin
        dv_hit[k+1] <= dv_hit[k];
        dv_sx[k+1]  <= dv_sx[k];
        dv_sy[k+1]  <= dv_sy[k];
        dv_sax[k+1] <= dv_sax[k];
        dv_say[k+1] <= dv_say[k];
        dv_den[k+1] <= dv_den[k];
        dv_rx[k+1]  <= gx ? dv_rx[k] - dsh : dv_rx[k];
        dv_ry[k+1]  <= gy ? dv_ry[k] - dsh : dv_ry[k];
        dv_qx[k+1]  <= dv_qx[k] | (QB'(gx) << B);
        dv_qy[k+1]  <= dv_qy[k] | (QB'(gy) << B);
      end
    end
  end

  assign px = place(dv_sax[QB], dv_sx[QB], dv_qx[QB]);
  assign py = place(dv_say[QB], dv_sy[QB], dv_qy[QB]);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (b_en) begin
      res_valid <= dv_valid[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      res.hit     <= dv_hit[QB];
      res.point_x <= dv_hit[QB] ? px : '0;
      res.point_y <= dv_hit[QB] ? py : '0;
    end
  end

endmodule
`default_nettype wire

FILE: sv/segment_intersection.sv
// segment_intersection: top level, front classifier, word queue and point back end
// depends on segint_pkg, segint_front, segint_queue, segint_back
//
//   channel   ports                       word
//   segment   seg, seg_valid, seg_ready   seg_in_t, two segments in Q16.16
//   result    res, res_valid, res_ready   seg_out_t, hit flag and point
//
// one word accepted per cycle when nothing stalls, results in order
// from acceptance to res_valid a word passes the first front stage, which loads at acceptance,
// two more front stages, the queue write, two multiply stages, the dividend register, one
// divider stage per quotient bit (COORD_WIDTH + 1) and the output register
// the divider pipeline depth (one restoring step per quotient bit) sets the latency
// a stall on res holds the back end, the queue of four words then fills before seg_ready drops
// synchronous reset empties the pipelines and the queue, payload registers are not reset
`default_nettype none
module segment_intersection
  import segint_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire seg_in_t seg,
  input  wire logic    seg_valid,
  output logic         seg_ready,
  output seg_out_t     res,
  output logic         res_valid,
  input  wire logic    res_ready
);

  // classified words between front and back
  logic   push_valid;
  qword_t push_word;
  logic   pop;
  qword_t pop_word;
  qstat_t qstat;

  // front: differences, cross products, exact hit test
  segint_front u_front (
    .clk        (clk),
    .rst        (rst),
    .seg        (seg),
    .seg_valid  (seg_valid),
    .seg_ready  (seg_ready),
    .push_valid (push_valid),
    .push_word  (push_word),
    .qstat      (qstat)
  );

  // queue lets the front keep taking words while the result side stalls
  segint_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push_valid),
    .push_word (push_word),
    .pop       (pop),
    .pop_word  (pop_word),
    .qstat     (qstat)
  );

  // back: numerator times direction, divide by denominator, place and saturate
  segint_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_word  (pop_word),
    .qstat     (qstat),
    .pop       (pop),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

endmodule
`default_nettype wire

FILE: sv/segint_check.sv
// segint_check: port level assertions for segment_intersection, with its bind
// depends on segint_pkg
`default_nettype none
module segint_check
  import segint_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire seg_in_t  seg,
  input wire logic     seg_valid,
  input wire logic     seg_ready,
  input wire seg_out_t res,
  input wire logic     res_valid,
  input wire logic     res_ready
);

  // a stalled result word holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result word changed while stalled");

  // no hit means a zero point
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.hit |-> res.point_x == '0 && res.point_y == '0)
    else $error("point not zero on a miss");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  // nothing can come out right after reset is released
  a_no_early: assert property (@(posedge clk)
    rst ##1 !rst |=> !res_valid)
    else $error("result appeared too soon after reset");

endmodule

bind segment_intersection segint_check u_chk (.*);
`default_nettype wire

FILE: test/segment_intersection_tb.sv
// segment_intersection_tb: self-checking bench for the segment intersection unit
// depends on segint_pkg and segment_intersection; exact wide-integer prediction of hit and point
`default_nettype none
module segment_intersection_tb;
  import segint_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LAT = COORD_WIDTH + 8;
  localparam longint CYCLE_LIMIT = 400000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  seg_in_t  seg = '0;
  logic     seg_valid = 1'b0;
  logic     seg_ready;
  seg_out_t res;
  logic     res_valid;
  logic     res_ready = 1'b0;

  // idling controls, percent of cycles
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;

  seg_out_t expected_q[$];
  int       mismatches = 0;
  int       words_sent = 0;
  int       words_checked = 0;
  int       hits_seen = 0;
  longint   cycles = 0;

  segment_intersection dut (
    .clk(clk), .rst(rst),
    .seg(seg), .seg_valid(seg_valid), .seg_ready(seg_ready),
    .res(res), .res_valid(res_valid), .res_ready(res_ready)
  );

  always #5 clk = ~clk;

  // ------------------------------------------------------------------
  // predictor: exact signed arithmetic, 200 bits is far more than needed
  // ------------------------------------------------------------------
  typedef logic signed [199:0] big_t;

  // numerator over denominator in the closed unit interval, denominator nonzero
  function automatic logic frac_in_unit(big_t num, big_t den);
    big_t n, d;
    n = num;
    d = den;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    return (n >= 0) && (n <= d);
  endfunction

  // quotient truncated toward zero, then clamp to coordinate range
  function automatic logic signed [COORD_WIDTH-1:0] point_coord(big_t base, big_t num,
                                                                big_t den);
    big_t q, v, hi, lo, an, ad;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    q = an / ad;
    if ((num < 0) != (den < 0)) q = -q;
    v = base + q;
    hi = (big_t'(1) <<< (COORD_WIDTH - 1)) - 1;
    lo = -(big_t'(1) <<< (COORD_WIDTH - 1));
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[COORD_WIDTH-1:0];
  endfunction

  function automatic seg_out_t predict_crossing(seg_in_t s);
    seg_out_t r;
    big_t sax, say, sbx, sby, dax, day, dbx, dby, ox, oy, den, na, nb;
    sax = big_t'(s.a_start_x);
    say = big_t'(s.a_start_y);
    sbx = big_t'(s.b_start_x);
    sby = big_t'(s.b_start_y);
    dax = big_t'(s.a_end_x) - sax;
    day = big_t'(s.a_end_y) - say;
    dbx = big_t'(s.b_end_x) - sbx;
    dby = big_t'(s.b_end_y) - sby;
    ox = sax - sbx;
    oy = say - sby;
    den = dby * dax - dbx * day;
    na = dbx * oy - dby * ox;
    nb = dax * oy - day * ox;
    r = '0;
    r.hit = (den != 0) && frac_in_unit(na, den) && frac_in_unit(nb, den);
    if (r.hit) begin
      r.point_x = point_coord(sax, na * dax, den);
      r.point_y = point_coord(say, na * day, den);
    end
    return r;
  endfunction

  // ------------------------------------------------------------------
  // receiver: random stall and result checking at the rising edge
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    seg_out_t want;
    cycles <= cycles + 1;
    if (!rst) begin
      if (res_valid && res_ready) begin
        words_checked++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: hit=%0b x=%0d y=%0d",
                     res.hit, res.point_x, res.point_y);
        end else begin
          want = expected_q.pop_front();
          if (want.hit) hits_seen++;
          if (res.hit !== want.hit || res.point_x !== want.point_x ||
              res.point_y !== want.point_y) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
                       want.hit, want.point_x, want.point_y,
                       res.hit, res.point_x, res.point_y);
          end
        end
      end
      res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // hard stop if the block stalls for good
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("segment_intersection_tb: errors");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // sender
  // ------------------------------------------------------------------
  // send one word, with an optional random gap before it
  // valid stays high straight into the next word when there is no gap
  task automatic send_word(seg_in_t s);
    logic took;
    while ($urandom_range(99) < send_idle_pct) begin
      seg_valid <= 1'b0;
      @(posedge clk);
    end
    seg <= s;
    seg_valid <= 1'b1;
    expected_q.push_back(predict_crossing(s));
    words_sent++;
    // ready is settled by the falling edge and holds to the next rising edge
    do begin
      @(negedge clk);
      took = seg_ready;
      @(posedge clk);
    end while (!took);
  endtask

  // wait for the pipeline to drain completely
  task automatic drain();
    seg_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [COORD_WIDTH-1:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 20)) - 10;       // tiny
      2: return ($signed($urandom_range(0, 200)) - 100) <<< 16;  // whole units
      default: return $urandom_range(1) ? 32'sh7fff_ffff - $urandom_range(3)
                                        : 32'sh8000_0000 + $urandom_range(3);
    endcase
  endfunction

  function automatic seg_in_t make_word(logic signed [COORD_WIDTH-1:0] asx, asy, aex, aey,
                                        bsx, bsy, bex, bey);
    seg_in_t s;
    s.a_start_x = asx; s.a_start_y = asy; s.a_end_x = aex; s.a_end_y = aey;
    s.b_start_x = bsx; s.b_start_y = bsy; s.b_end_x = bex; s.b_end_y = bey;
    return s;
  endfunction

  localparam logic signed [COORD_WIDTH-1:0] MAXC = 32'sh7fff_ffff;
  localparam logic signed [COORD_WIDTH-1:0] MINC = 32'sh8000_0000;
  localparam logic signed [COORD_WIDTH-1:0] ONE = 32'sh0001_0000;

  // crossings, end-point touches, parallel, collinear, degenerate, extremes
  task automatic test_directed();
    send_word(make_word(-ONE, 0, ONE, 0, 0, -ONE, 0, ONE));          // plain cross
    send_word(make_word(0, 0, 2*ONE, 2*ONE, 0, 2*ONE, 2*ONE, 0));    // diagonal cross
    send_word(make_word(0, 0, ONE, 0, ONE, -ONE, ONE, ONE));         // uA exactly 1
    send_word(make_word(0, 0, ONE, 0, 0, -ONE, 0, ONE));             // uA exactly 0
    send_word(make_word(-ONE, 0, ONE, 0, 0, 0, 0, ONE));             // uB exactly 0
    send_word(make_word(-ONE, 0, ONE, 0, 0, -ONE, 0, 0));            // uB exactly 1
    send_word(make_word(0, 0, ONE, 0, 0, ONE, ONE, ONE));            // parallel
    send_word(make_word(0, 0, 2*ONE, 0, ONE, 0, 3*ONE, 0));          // collinear overlap
    send_word(make_word(ONE, ONE, ONE, ONE, 0, 0, 2*ONE, 2*ONE));    // zero-length A
    send_word(make_word(0, 0, ONE, 0, 2*ONE, -ONE, 2*ONE, ONE));     // miss past end of A
    send_word(make_word(0, 0, ONE, ONE, 0, ONE+1, ONE, 1));          // cross at a non-integer point
    send_word(make_word(MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC));  // full range
    send_word(make_word(MAXC, 0, MINC, 0, 0, MAXC, 0, MINC));
    send_word(make_word(MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC, MINC));
    send_word(make_word(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC));
    send_word(make_word(MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC));
    send_word(make_word(MINC, 0, MAXC, 1, MAXC, MINC, MINC, MAXC));
    send_word(make_word(-1, -1, 1, 1, -1, 1, 1, -1));                // tiny cross
    send_word(make_word(0, 0, 3, 0, 1, -2, 2, 5));                   // truncated point
    send_word(make_word(0, 0, -3, 0, -1, -2, -2, 5));                // negative truncation
    send_word('1);
    send_word('0);
  endtask

  // random words: about half built to cross, the rest free noise
  task automatic test_random(int count);
    seg_in_t s;
    int mode;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(3);
      s = make_word(rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode),
                    rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode));
      if ($urandom_range(1)) begin
        // mirror B through the midpoint region of A so the pair tends to cross
        s.b_start_x = s.a_start_x / 2 + s.a_end_x / 2 + (s.a_start_y / 4 - s.a_end_y / 4);
        s.b_start_y = s.a_start_y / 2 + s.a_end_y / 2 - (s.a_start_x / 4 - s.a_end_x / 4);
        s.b_end_x = s.a_start_x / 2 + s.a_end_x / 2 - (s.a_start_y / 4 - s.a_end_y / 4);
        s.b_end_y = s.a_start_y / 2 + s.a_end_y / 2 + (s.a_start_x / 4 - s.a_end_x / 4);
        if ($urandom_range(3) == 0) s.b_end_x = s.b_end_x + $signed($urandom_range(4)) - 2;
      end
      send_word(s);
    end
  endtask

  // a fresh random stream under each idling pattern
  task automatic test_idling();
    send_idle_pct = 76; recv_stall_pct = 0;  test_random(350);
    send_idle_pct = 0;  recv_stall_pct = 76; test_random(350);
    send_idle_pct = 33; recv_stall_pct = 33; test_random(350);
  endtask

  // full drain mid-stream, then resume back to back
  task automatic test_pause();
    send_idle_pct = 0; recv_stall_pct = 0;
    test_random(20);
    drain();
    test_random(180);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(400);
    test_idling();
    test_pause();
    drain();
    repeat (LAT + 10) @(posedge clk);
    $display("sent %0d segment pairs, checked %0d results, %0d hits, %0d mismatches",
             words_sent, words_checked, hits_seen, mismatches);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("segment_intersection_tb: clean");
    else
      $display("segment_intersection_tb: errors");
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
sv/segint_pkg.sv
sv/segint_front.sv
sv/segint_queue.sv
sv/segint_back.sv
sv/segment_intersection.sv
sv/segint_check.sv
test/segment_intersection_tb.sv
